### rtl/luhn_pkg.sv
// ----------------------------------------------------------------------------
// luhn_pkg
// Shared constants, types and helpers for the Luhn mod-10 card number check.
// ----------------------------------------------------------------------------
package luhn_pkg;

   // Largest number of decimal digits a card number may have
   localparam int MAX_DIGITS = 19;

   // Field widths
   localparam int NUM_W   = 64;
   localparam int COUNT_W = 5;
   localparam int KIND_W  = 2;
   localparam int DIGIT_W = 4;

   // Internal widths
   localparam int BCD_W     = DIGIT_W * MAX_DIGITS;
   localparam int DIG_IDX_W = $clog2(MAX_DIGITS);
   localparam int BIT_IDX_W = $clog2(NUM_W);

   // Card class rules
   localparam int LEN_SHORT = 13;
   localparam int LEN_MID   = 15;
   localparam int LEN_LONG  = 16;
   localparam int LEAD_FOUR = 4;

   // 10 ** n, evaluated at elaboration
   function automatic logic [NUM_W-1:0] pow10(input int n);
      logic [NUM_W-1:0] acc;
      acc = NUM_W'(1);
      for (int k = 0; k < n; k++) begin
         acc = acc * NUM_W'(10);
      end
      return acc;
   endfunction

   // Smallest value with more than MAX_DIGITS decimal digits
   localparam logic [NUM_W-1:0] DIGIT_LIMIT = pow10(MAX_DIGITS);

   // Card class codes
   typedef enum logic [KIND_W-1:0] {
      KIND_NONE   = 2'd0,
      KIND_PFX4   = 2'd1,
      KIND_PFX3X  = 2'd2,
      KIND_PFX5X  = 2'd3
   } kind_type;

   // Sequencer states
   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_CONV = 2'd1,
      S_SCAN = 2'd2,
      S_DONE = 2'd3
   } state_type;

endpackage

### rtl/luhn_card_number_check.sv
// ----------------------------------------------------------------------------
// luhn_card_number_check
// Converts a binary card number to decimal digits one bit per cycle, then
// walks the digits one per cycle to form the Luhn sum, digit count and class.
// ----------------------------------------------------------------------------
//  channel | ports                                      | direction
//  --------+--------------------------------------------+----------
//  request | req_valid, req_ready, req_card_number      | in
//  result  | rsp_valid, rsp_ready, rsp_luhn_valid,      | out
//          | rsp_digit_count, rsp_card_kind             |
//
//  One beat passes through a 64-step shift-and-add-3 conversion, then one digit
//  per cycle through the sum unit.
//  req_ready is high only while the sequencer is idle.
//  The result sits in an output register; a new beat may be accepted while it
//  waits. A finished item holds in S_DONE while that register is full and rsp_ready is low.
//  Synchronous active-high reset clears the sequencer and rsp_valid.
// ----------------------------------------------------------------------------
module luhn_card_number_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [luhn_pkg::NUM_W-1:0]    req_card_number,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_luhn_valid,
   output logic [luhn_pkg::COUNT_W-1:0]  rsp_digit_count,
   output logic [luhn_pkg::KIND_W-1:0]   rsp_card_kind
);

   localparam int BCD_W = luhn_pkg::BCD_W;
   localparam int DW    = luhn_pkg::DIGIT_W;

   luhn_pkg::state_type state_ff, state_in;

   logic [luhn_pkg::NUM_W-1:0]     bin_ff, bin_in;
   logic [BCD_W-1:0]               bcd_ff, bcd_in;
   logic [luhn_pkg::BIT_IDX_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [luhn_pkg::DIG_IDX_W-1:0] dig_cnt_ff, dig_cnt_in;
   logic [luhn_pkg::DIG_IDX_W-1:0] nz_pos_ff, nz_pos_in;
   logic                           over_ff, over_in;
   logic [DW-1:0]                  sum_ff, sum_in;
   logic [DW-1:0]                  prev_ff, prev_in;
   logic [DW-1:0]                  lead_ff, lead_in;
   logic [DW-1:0]                  next_ff, next_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_luhn_ff, rsp_luhn_in;
   logic [luhn_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [luhn_pkg::KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;

   logic                           accept;
   logic                           conv_last;
   logic                           scan_last;
   logic                           load_rsp;
   logic [BCD_W-1:0]               bcd_adj;
   logic [DW-1:0]                  digit;
   logic [DW:0]                    dbl;
   logic [DW-1:0]                  contrib;
   logic [DW:0]                    sum_raw;
   logic                           res_valid;
   logic [luhn_pkg::COUNT_W-1:0]   res_count;
   luhn_pkg::kind_type             res_kind;

   assign accept    = req_valid && req_ready;
   assign conv_last = (bit_cnt_ff == luhn_pkg::BIT_IDX_W'(luhn_pkg::NUM_W - 1));
   assign scan_last = (dig_cnt_ff == luhn_pkg::DIG_IDX_W'(luhn_pkg::MAX_DIGITS - 1));
   assign load_rsp  = (state_ff == luhn_pkg::S_DONE) && (!rsp_valid_ff || rsp_ready);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         luhn_pkg::S_IDLE: if (accept)    state_in = luhn_pkg::S_CONV;
         luhn_pkg::S_CONV: if (conv_last) state_in = luhn_pkg::S_SCAN;
         luhn_pkg::S_SCAN: if (scan_last) state_in = luhn_pkg::S_DONE;
         luhn_pkg::S_DONE: if (load_rsp)  state_in = luhn_pkg::S_IDLE;
         default:                         state_in = luhn_pkg::S_IDLE;
      endcase
   end

   // Add 3 to every BCD digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < luhn_pkg::MAX_DIGITS; i++) begin
         if (bcd_ff[i*DW +: DW] >= DW'(5)) begin
            bcd_adj[i*DW +: DW] = bcd_ff[i*DW +: DW] + DW'(3);
         end else begin
            bcd_adj[i*DW +: DW] = bcd_ff[i*DW +: DW];
         end
      end
   end

   // Weight one digit and fold it into the running sum mod 10
   always_comb begin
      digit = bcd_ff[DW-1:0];
      dbl   = {digit, 1'b0};
      if (!dig_cnt_ff[0]) begin
         contrib = digit;
      end else if (dbl >= (DW+1)'(10)) begin
         contrib = DW'(dbl - (DW+1)'(9));
      end else begin
         contrib = dbl[DW-1:0];
      end
      sum_raw = {1'b0, sum_ff} + {1'b0, contrib};
   end

   // Datapath updates driven by the sequencer
   always_comb begin
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      nz_pos_in  = nz_pos_ff;
      over_in    = over_ff;
      sum_in     = sum_ff;
      prev_in    = prev_ff;
      lead_in    = lead_ff;
      next_in    = next_ff;
      unique case (state_ff)
         luhn_pkg::S_IDLE: begin
            if (accept) begin
               bin_in     = req_card_number;
               bcd_in     = '0;
               bit_cnt_in = '0;
               dig_cnt_in = '0;
               nz_pos_in  = '0;
               over_in    = (req_card_number >= luhn_pkg::DIGIT_LIMIT);
               sum_in     = '0;
               prev_in    = '0;
               lead_in    = '0;
               next_in    = '0;
            end
         end
         luhn_pkg::S_CONV: begin
            bcd_in     = {bcd_adj[BCD_W-2:0], bin_ff[luhn_pkg::NUM_W-1]};
            bin_in     = {bin_ff[luhn_pkg::NUM_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + luhn_pkg::BIT_IDX_W'(1);
         end
         luhn_pkg::S_SCAN: begin
            bcd_in     = {DW'(0), bcd_ff[BCD_W-1:DW]};
            dig_cnt_in = dig_cnt_ff + luhn_pkg::DIG_IDX_W'(1);
            sum_in     = (sum_raw >= (DW+1)'(10)) ? DW'(sum_raw - (DW+1)'(10))
                                                  : sum_raw[DW-1:0];
            prev_in    = digit;
            if (digit != '0) begin
               nz_pos_in = dig_cnt_ff;
               lead_in   = digit;
               next_in   = prev_ff;
            end
         end
         luhn_pkg::S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // Form the result from the finished scan
   always_comb begin
      res_valid = !over_ff && (sum_ff == '0);
      res_count = over_ff ? luhn_pkg::COUNT_W'(luhn_pkg::MAX_DIGITS)
                          : luhn_pkg::COUNT_W'(nz_pos_ff) + luhn_pkg::COUNT_W'(1);
      res_kind  = luhn_pkg::KIND_NONE;
      if (res_valid) begin
         priority if (((res_count == luhn_pkg::COUNT_W'(luhn_pkg::LEN_SHORT)) ||
                       (res_count == luhn_pkg::COUNT_W'(luhn_pkg::LEN_LONG))) &&
                      (lead_ff == DW'(luhn_pkg::LEAD_FOUR))) begin
            res_kind = luhn_pkg::KIND_PFX4;
         end else if ((res_count == luhn_pkg::COUNT_W'(luhn_pkg::LEN_MID)) &&
                      (lead_ff == DW'(3)) &&
                      ((next_ff == DW'(4)) || (next_ff == DW'(7)))) begin
            res_kind = luhn_pkg::KIND_PFX3X;
         end else if ((res_count == luhn_pkg::COUNT_W'(luhn_pkg::LEN_LONG)) &&
                      (lead_ff == DW'(5)) &&
                      (next_ff >= DW'(1)) && (next_ff <= DW'(5))) begin
            res_kind = luhn_pkg::KIND_PFX5X;
         end else begin
            res_kind = luhn_pkg::KIND_NONE;
         end
      end
   end

   // Output register: load when done, drop on a taken beat
   always_comb begin
      rsp_luhn_in  = rsp_luhn_ff;
      rsp_count_in = rsp_count_ff;
      rsp_kind_in  = rsp_kind_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_luhn_in  = res_valid;
         rsp_count_in = res_count;
         rsp_kind_in  = res_kind;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= luhn_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      bin_ff       <= bin_in;
      bcd_ff       <= bcd_in;
      bit_cnt_ff   <= bit_cnt_in;
      dig_cnt_ff   <= dig_cnt_in;
      nz_pos_ff    <= nz_pos_in;
      over_ff      <= over_in;
      sum_ff       <= sum_in;
      prev_ff      <= prev_in;
      lead_ff      <= lead_in;
      next_ff      <= next_in;
      rsp_luhn_ff  <= rsp_luhn_in;
      rsp_count_ff <= rsp_count_in;
      rsp_kind_ff  <= rsp_kind_in;
   end

   assign req_ready       = (state_ff == luhn_pkg::S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_luhn_valid  = rsp_luhn_ff;
   assign rsp_digit_count = rsp_count_ff;
   assign rsp_card_kind   = rsp_kind_ff;

   // Checks
   a_start_conv: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == luhn_pkg::S_CONV) && (bit_cnt_ff == '0))
      else $error("conversion did not start after an accepted beat");

   a_conv_to_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == luhn_pkg::S_CONV) && conv_last |=>
         (state_ff == luhn_pkg::S_SCAN) && (dig_cnt_ff == '0))
      else $error("scan did not follow the last conversion step");

   a_kind_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_card_kind != luhn_pkg::KIND_NONE) |-> rsp_luhn_valid)
      else $error("card class reported on a failed check");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digit_count != '0) &&
                    (rsp_digit_count <= luhn_pkg::COUNT_W'(luhn_pkg::MAX_DIGITS)))
      else $error("digit count out of range");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == luhn_pkg::S_DONE) && rsp_valid_ff && !rsp_ready |=>
         (state_ff == luhn_pkg::S_DONE))
      else $error("finished item lost while the output register was full");

endmodule
